[design/knds_pkg.sv]
// -----------------------------------------------------------------------------
// knds_pkg: shared types and constants for the nearest-distance-sum block.
// Holds the default store depth, the field widths and the status struct that
// passes from the distance unit to the top level.
// -----------------------------------------------------------------------------
package knds_pkg;

  localparam int unsigned MaxCitiesDefault = 64;
  localparam int unsigned CoordW = 16;
  localparam int unsigned DistW = 17;
  localparam int unsigned SumW = 23;
  localparam int unsigned CountW = 6;
  localparam int unsigned SqW = 34;
  localparam logic [CountW-1:0] NearestReset = CountW'(1);

  // Handshake between the sequencer and the square-root unit.
  typedef struct packed {
    logic busy;
    logic done;
  } knds_sqrt_stat_t;

endpackage

[design/knds_isqrt.sv]
// -----------------------------------------------------------------------------
// knds_isqrt: iterative integer square root.
// Takes the squared distance and produces floor(sqrt) one result bit per step,
// bringing down two radicand bits each step, over seventeen steps with one shared subtract-and-compare unit.
// -----------------------------------------------------------------------------
module knds_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [knds_pkg::SqW-1:0]   radicand,
  output logic [knds_pkg::DistW-1:0] root,
  output knds_pkg::knds_sqrt_stat_t  stat
);
  import knds_pkg::*;

  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] Steps = StepW'(DistW);

  logic [SqW-1:0]   rem_r, rem_nxt;
  logic [SqW-1:0]   val_r, val_nxt;
  logic [DistW-1:0] root_r, root_nxt;
  logic [StepW-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SqW+1:0]   trial;
  logic [SqW+1:0]   rem_shift;

  // One restoring step: bring down two radicand bits and try 4*root+1.
  always_comb begin
    rem_shift = {rem_r, val_r[SqW-1 -: 2]};
    trial     = rem_shift - {{(SqW-DistW){1'b0}}, root_r, 2'b01};
    rem_nxt   = rem_r;
    val_nxt   = val_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      val_nxt  = radicand;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[SqW-3:0], 2'b00};
      if (!trial[SqW+1]) begin
        rem_nxt  = trial[SqW-1:0];
        root_nxt = {root_r[DistW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_shift[SqW-1:0];
        root_nxt = {root_r[DistW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + StepW'(1);
      if (cnt_r == Steps - StepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    val_r  <= val_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[design/k_nearest_distance_sum.sv]
// -----------------------------------------------------------------------------
// k_nearest_distance_sum: per-city sum of the n+1 smallest distances.
// Stores a map of cities, then for each city computes all distances with a
// shared square-root unit and picks the smallest ones by repeated scans.
// -----------------------------------------------------------------------------
// Loading: coordinate items are taken only in the load state and not while a
// result waits; no item of a new map is taken until its final result is sent.
// Each distance costs a 17-step square root plus a coordinate memory read, and
// each selection scans the distance buffer.
// Reset: synchronous, active low; clears control state, city count and sets
// nearest_count to 1. Stores need no clearing.
module k_nearest_distance_sum #(
  parameter int unsigned MAX_CITIES = knds_pkg::MaxCitiesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // coord_x [15:0], coord_y [31:16]
  input  logic        in_tlast,   // last_city
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // city_index [5:0], nearest_sum [28:6], zeros
  output logic        out_tuser,  // count_error
  output logic        out_tlast,  // last_result
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata   // nearest_count
);
  import knds_pkg::*;

  localparam int unsigned IdxW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_CITIES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CITIES);

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_RDA   = 8'b0000_0010,
    S_RDB   = 8'b0000_0100,
    S_SQ    = 8'b0000_1000,
    S_WAIT  = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_PICK  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Coordinate and distance memories.
  logic [CoordW-1:0] xmem [MAX_CITIES];
  logic [CoordW-1:0] ymem [MAX_CITIES];
  logic [DistW-1:0]  dmem [MAX_CITIES];
  logic [CoordW-1:0] xrd_r, yrd_r;
  logic [DistW-1:0]  drd_r;
  logic [CoordW-1:0] ax_r, ay_r;
  logic [MAX_CITIES-1:0] used_r, used_nxt;

  logic [CntW-1:0]   count_r, count_nxt;
  logic [CountW-1:0] near_r;
  logic [IdxW-1:0]   city_r, city_nxt;
  logic [CntW-1:0]   j_r, j_nxt;
  logic [CountW:0]   take_r, take_nxt;
  logic [DistW-1:0]  best_r, best_nxt;
  logic [IdxW-1:0]   bidx_r, bidx_nxt;
  logic              found_r, found_nxt;
  logic              rdv_r, rdv_nxt;
  logic [IdxW-1:0]   rdi_r, rdi_nxt;
  logic [SumW-1:0]   sum_r, sum_nxt;
  logic              err_r, err_nxt;
  logic              olast_r, olast_nxt;
  logic [IdxW-1:0]   rd_addr;
  logic              mem_we;
  logic [IdxW-1:0]   wr_addr;

  logic signed [CoordW:0]   dx, dy;
  logic [SqW-1:0]           sq_r;
  logic                     sq_start;
  logic [DistW-1:0]         root;
  knds_sqrt_stat_t          sstat;
  logic                     accept_in;

  assign accept_in = in_tvalid && in_tready;
  assign in_tready = (state_r == S_LOAD) && !out_tvalid;
  assign wr_addr   = count_r[IdxW-1:0];
  assign mem_we    = accept_in && (count_r < MaxCnt);

  // Coordinate store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      xmem[wr_addr] <= in_tdata[15:0];
      ymem[wr_addr] <= in_tdata[31:16];
    end
    xrd_r <= xmem[rd_addr];
    yrd_r <= ymem[rd_addr];
  end

  // Distance buffer: written when a root completes, read during scans.
  always_ff @(posedge clk) begin
    if (sstat.done) begin
      dmem[j_r[IdxW-1:0]] <= root;
    end
    drd_r <= dmem[rd_addr];
  end

  // Squared distance from the registered coordinates of city and partner.
  assign dx = {ax_r[CoordW-1], ax_r} - {xrd_r[CoordW-1], xrd_r};
  assign dy = {ay_r[CoordW-1], ay_r} - {yrd_r[CoordW-1], yrd_r};

  // The city's own coordinates arrive on the first partner pass.
  always_ff @(posedge clk) begin
    if (state_r == S_RDB && j_r == '0) begin
      ax_r <= xrd_r;
      ay_r <= yrd_r;
    end
    if (state_r == S_SQ) begin
      sq_r <= SqW'(dx * dx) + SqW'(dy * dy);
    end
  end

  assign sq_start = (state_r == S_WAIT) && !sstat.busy && !sstat.done && !rdv_r;

  knds_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_r),
    .root     (root),
    .stat     (sstat)
  );

  // Read address: city during RDA, partner j otherwise, scan index in SCAN.
  always_comb begin
    if (state_r == S_RDA) begin
      rd_addr = city_r;
    end else if (state_r == S_SCAN) begin
      rd_addr = j_r[IdxW-1:0];
    end else begin
      rd_addr = j_nxt[IdxW-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    city_nxt  = city_r;
    j_nxt     = j_r;
    take_nxt  = take_r;
    best_nxt  = best_r;
    bidx_nxt  = bidx_r;
    found_nxt = found_r;
    rdv_nxt   = 1'b0;
    rdi_nxt   = rdi_r;
    sum_nxt   = sum_r;
    err_nxt   = err_r;
    olast_nxt = olast_r;
    used_nxt  = used_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept_in) begin
          count_nxt = mem_we ? count_r + CntW'(1) : count_r;
          if (in_tlast) begin
            if (CntW'(near_r) >= count_nxt) begin
              err_nxt   = 1'b1;
              city_nxt  = '0;
              sum_nxt   = '0;
              olast_nxt = 1'b1;
              state_nxt = S_OUT;
            end else begin
              err_nxt   = 1'b0;
              city_nxt  = '0;
              j_nxt     = '0;
              state_nxt = S_RDA;
            end
          end
        end
      end
      S_RDA: begin
        // City coordinates are read this cycle (address from city_r).
        j_nxt     = '0;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        state_nxt = S_SQ;
      end
      S_SQ: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sstat.done) begin
          if (j_r + CntW'(1) == count_r) begin
            j_nxt     = '0;
            take_nxt  = {1'b0, near_r} + (CountW+1)'(1);
            sum_nxt   = '0;
            used_nxt  = '0;
            found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            j_nxt     = j_r + CntW'(1);
            state_nxt = S_RDB;
          end
        end
      end
      S_SCAN: begin
        // Issue read for j_r; compare data read last cycle.
        if (rdv_r && !used_r[rdi_r] && (!found_r || drd_r < best_r)) begin
          best_nxt  = drd_r;
          bidx_nxt  = rdi_r;
          found_nxt = 1'b1;
        end
        if (j_r < count_r) begin
          rdv_nxt = 1'b1;
          rdi_nxt = j_r[IdxW-1:0];
          j_nxt   = j_r + CntW'(1);
        end else begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        sum_nxt            = sum_r + SumW'(best_r);
        used_nxt[bidx_r]   = 1'b1;
        take_nxt           = take_r - (CountW+1)'(1);
        found_nxt          = 1'b0;
        j_nxt              = '0;
        if (take_r == (CountW+1)'(1)) begin
          olast_nxt = (CntW'(city_r) + CntW'(1) == count_r);
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          if (olast_r) begin
            count_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            city_nxt  = city_r + IdxW'(1);
            state_nxt = S_RDA;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Datapath registers and sequencer state.
  always_ff @(posedge clk) begin
    city_r  <= city_nxt;
    j_r     <= j_nxt;
    take_r  <= take_nxt;
    best_r  <= best_nxt;
    bidx_r  <= bidx_nxt;
    found_r <= found_nxt;
    rdi_r   <= rdi_nxt;
    sum_r   <= sum_nxt;
    err_r   <= err_nxt;
    olast_r <= olast_nxt;
    used_r  <= used_nxt;
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      near_r  <= NearestReset;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rdv_r   <= rdv_nxt;
      if (cfg_we) begin
        near_r <= cfg_wdata;
      end
    end
  end

  // Result item.
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {3'b000, sum_r, CountW'(city_r)};
  assign out_tuser  = err_r;
  assign out_tlast  = olast_r;

endmodule

[design/knds_checker.sv]
// -----------------------------------------------------------------------------
// knds_checker: port-level checks for the nearest-distance-sum block.
// Watches the handshakes and the result fields over time.
// -----------------------------------------------------------------------------
module knds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // No new city is taken while a result waits.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input ready while result pending");

  // An error item carries zero index and sum and ends the map.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && out_tdata == 32'd0))
    else $error("malformed error item");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

  // After the final result the block is ready to load again.
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not ready after final result");

endmodule

bind k_nearest_distance_sum knds_checker u_knds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
